// File: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'd32;

  localparam int unsigned APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-1:0] ADDR_TEXT_ATTR = 3'd0;
  localparam logic [7:0] TEXT_ATTR_RESET = 8'd7;

endpackage

// File: rtl/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/tcw_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_regs
// APB configuration register file holding the text attribute.
// ----------------------------------------------------------------------------
module tcw_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [7:0]                      text_attr_o
);

  logic [7:0] attr_q, attr_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    attr_d = attr_q;
    if (wr_en && (paddr == tcw_pkg::ADDR_TEXT_ATTR)) begin
      attr_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::TEXT_ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  assign prdata      = (paddr == tcw_pkg::ADDR_TEXT_ATTR) ? {24'd0, attr_q} : 32'd0;
  assign text_attr_o = attr_q;

endmodule

// File: rtl/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine over a screen RAM of attribute/character cells.
//
//   channel   direction  handshake                 payload
//   command   in         start && !busy            operation_i, char_code_i, cell_index_i
//   result    out        done_o, one-cycle strobe  cell_data_o, cursor_row_o, cursor_col_o
//   config    in         APB, psel/penable/pwrite  pwdata (text attribute at 0x0)
//
// Printable character and cell read: one RAM write or registered read before done_o.
// Newline without scroll, unused op, out-of-range read: done_o straight from idle.
// Clear sweeps every cell; a scroll adds a sweep, one RAM cell each cycle.
// Reset clears cursor and control state; the screen RAM is not cleared.
// The result receiver cannot stall; busy holds commands off during a sweep.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int unsigned SCREEN_WIDTH  = 80,
  parameter int unsigned SCREEN_HEIGHT = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     operation_i,
  input  logic [7:0]                     char_code_i,
  input  logic [10:0]                    cell_index_i,
  output logic                           done_o,
  output logic [15:0]                    cell_data_o,
  output logic [4:0]                     cursor_row_o,
  output logic [6:0]                     cursor_col_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(SCREEN_HEIGHT + 1);
  localparam int unsigned CW    = $clog2(SCREEN_WIDTH);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WRITE  = 6'b000010,
    ST_READ   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_BLANK  = 6'b010000,
    ST_CLEAR  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [RW-1:0]   row_q, row_d;
  logic [CW-1:0]   col_q, col_d;
  logic [AW-1:0]   scan_q, scan_d;
  logic [AW-1:0]   copy_addr_q, copy_addr_d;
  logic            copy_vld_q, copy_vld_d;
  logic            scroll_wr_q, scroll_wr_d;
  logic [7:0]      ch_q, ch_d;
  logic [15:0]     data_q, data_d;
  logic            done_q, done_d;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [15:0]     ram_wdata, ram_rdata;
  logic [AW-1:0]   cursor_addr;
  logic [7:0]      text_attr;
  logic [15:0]     blank_cell;
  logic            accept;

  tcw_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .text_attr_o(text_attr)
  );

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_screen_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign blank_cell  = {text_attr, tcw_pkg::BLANK_CODE};
  assign cursor_addr = AW'(32'(row_q) * SCREEN_WIDTH + 32'(col_q));

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    scan_d      = scan_q;
    copy_addr_d = copy_addr_q;
    copy_vld_d  = copy_vld_q;
    scroll_wr_d = scroll_wr_q;
    ch_d        = ch_q;
    data_d      = data_q;
    done_d      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = scan_q;
    ram_wdata   = blank_cell;
    ram_re      = 1'b0;
    ram_raddr   = scan_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          data_d      = 16'd0;
          ch_d        = char_code_i;
          scan_d      = '0;
          copy_vld_d  = 1'b0;
          scroll_wr_d = 1'b0;
          case (tcw_pkg::op_e'(operation_i))
            tcw_pkg::OP_PUT: begin
              if (char_code_i == tcw_pkg::NEWLINE_CODE) begin
                col_d = '0;
                if (row_q == RW'(SCREEN_HEIGHT)) begin
                  state_d = ST_SCROLL;
                end else begin
                  row_d  = row_q + 1'b1;
                  done_d = 1'b1;
                end
              end else if (row_q == RW'(SCREEN_HEIGHT)) begin
                row_d       = RW'(SCREEN_HEIGHT - 1);
                scroll_wr_d = 1'b1;
                state_d     = ST_SCROLL;
              end else begin
                state_d = ST_WRITE;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              state_d = ST_CLEAR;
            end
            tcw_pkg::OP_READ: begin
              if (32'(cell_index_i) < CELLS) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(cell_index_i);
                state_d   = ST_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = cursor_addr;
        ram_wdata = {text_attr, ch_q};
        if (col_q == CW'(SCREEN_WIDTH - 1)) begin
          col_d = '0;
          if (row_q == RW'(SCREEN_HEIGHT - 1)) begin
            scan_d      = '0;
            copy_vld_d  = 1'b0;
            scroll_wr_d = 1'b0;
            state_d     = ST_SCROLL;
          end else begin
            row_d   = row_q + 1'b1;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          col_d   = col_q + 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        data_d  = ram_rdata;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCROLL: begin
        if (copy_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = copy_addr_q;
          ram_wdata = ram_rdata;
        end
        if (scan_q < AW'(CELLS - SCREEN_WIDTH)) begin
          ram_re      = 1'b1;
          ram_raddr   = scan_q + AW'(SCREEN_WIDTH);
          copy_vld_d  = 1'b1;
          copy_addr_d = scan_q;
          scan_d      = scan_q + 1'b1;
        end else begin
          copy_vld_d = 1'b0;
          state_d    = ST_BLANK;
        end
      end
      ST_BLANK: begin
        ram_we = 1'b1;
        if (scan_q == AW'(CELLS - 1)) begin
          if (scroll_wr_q) begin
            state_d = ST_WRITE;
          end else begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (scan_q == AW'(CELLS - 1)) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      scan_q      <= '0;
      copy_vld_q  <= 1'b0;
      scroll_wr_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      scan_q      <= scan_d;
      copy_vld_q  <= copy_vld_d;
      scroll_wr_q <= scroll_wr_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    copy_addr_q <= copy_addr_d;
    ch_q        <= ch_d;
    data_q      <= data_d;
  end

  assign done_o       = done_q;
  assign cell_data_o  = data_q;
  assign cursor_row_o = 5'(row_q);
  assign cursor_col_o = 7'(col_q);

  a_done_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("result strobe without a transfer in progress");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= RW'(SCREEN_HEIGHT))
    else $error("cursor row beyond pending row");

  a_write_row_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> (row_q < RW'(SCREEN_HEIGHT)))
    else $error("cell write at pending row");

  a_ram_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(ram_waddr) < CELLS))
    else $error("screen write beyond buffer");

endmodule
